// File: hdl/apr_pkg.sv
// Shared constants and result type for the aging page replacement core.
package apr_pkg;

   localparam int PAGE_W   = 16;
   localparam int INDEX_W  = 4;
   localparam int FAULT_W  = 16;
   localparam int CFG_W    = 5;
   localparam int AGE_W    = 8;

   localparam logic [AGE_W-1:0]   AGE_MSB      = 8'h80;
   localparam logic [FAULT_W-1:0] FAULT_MAX    = 16'hFFFF;
   localparam logic [CFG_W-1:0]   FRAMES_RESET = 5'd16;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] frame_index;
      logic [FAULT_W-1:0] fault_count;
   } result_type;

endpackage

// File: hdl/apr_req_if.sv
// Request, response and register-write channel interfaces.
interface apr_req_if;
   import apr_pkg::*;
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page;
   logic              start_run;
   modport source (output valid, output page, output start_run, input ready);
   modport sink   (input valid, input page, input start_run, output ready);
endinterface

interface apr_rsp_if;
   import apr_pkg::*;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [INDEX_W-1:0] frame_index;
   logic [FAULT_W-1:0] fault_count;
   modport source (output valid, output hit, output frame_index, output fault_count,
                   input ready);
   modport sink   (input valid, input hit, input frame_index, input fault_count,
                   output ready);
endinterface

interface apr_csr_if;
   import apr_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/apr_cell.sv
// One frame of the replacement chain: holds a frame and forwards the lookup probe.
module apr_cell #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16,
   parameter int K          = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic [$clog2(MAX_FRAMES+1)-1:0] n_frames,
   input  logic clear,
   input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)*2+PAGE_BITS+11:0] tok_in,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)*2+PAGE_BITS+11:0] tok_out,
   input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)+PAGE_BITS+1:0]   upd_in
);
   import apr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   typedef struct packed {
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic                 found;
      logic [IDX_W-1:0]     hit_idx;
      logic [AGE_W:0]       best_age;
      logic [IDX_W-1:0]     best_idx;
      logic                 spare;
   } token_type;

   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [IDX_W-1:0]     idx;
      logic [PAGE_BITS-1:0] page;
   } update_type;

   token_type            tok_i;
   token_type            tok_ff;
   token_type            tok_in_next;
   update_type           upd;
   logic                 valid_ff,  valid_in;
   logic [PAGE_BITS-1:0] page_ff,   page_in;
   logic [AGE_W-1:0]     age_ff,    age_in;
   logic                 active;
   logic                 mine;
   logic [AGE_W-1:0]     age_eff;

   assign tok_i   = token_type'(tok_in);
   assign upd     = update_type'(upd_in);
   assign tok_out = tok_ff;
   assign active  = 32'(n_frames) > K;
   assign mine    = upd.idx == IDX_W'(K);
   assign age_eff = valid_ff ? age_ff : '0;

   // probe: first matching frame and lowest-index minimum age
   always_comb begin
      tok_in_next = tok_i;
      if (tok_i.valid && active) begin
         if (!tok_i.found && valid_ff && page_ff == tok_i.page) begin
            tok_in_next.found   = 1'b1;
            tok_in_next.hit_idx = IDX_W'(K);
         end
         if ({1'b0, age_eff} < tok_i.best_age) begin
            tok_in_next.best_age = {1'b0, age_eff};
            tok_in_next.best_idx = IDX_W'(K);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      age_in   = age_ff;
      if (clear) begin
         valid_in = 1'b0;
         age_in   = '0;
      end else if (upd.valid && active) begin
         if (mine && upd.hit) begin
            age_in = (age_ff | AGE_MSB) >> 1;
         end else if (mine) begin
            valid_in = 1'b1;
            page_in  = upd.page;
            age_in   = AGE_MSB >> 1;
         end else begin
            age_in = age_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         age_ff       <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         age_ff       <= age_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      page_ff           <= page_in;
      tok_ff.page       <= tok_in_next.page;
      tok_ff.found      <= tok_in_next.found;
      tok_ff.hit_idx    <= tok_in_next.hit_idx;
      tok_ff.best_age   <= tok_in_next.best_age;
      tok_ff.best_idx   <= tok_in_next.best_idx;
      tok_ff.spare      <= tok_in_next.spare;
   end

endmodule

// File: hdl/apr_ctrl.sv
// Sequencer: accepts references, launches probes, commits updates, holds results.
module apr_ctrl #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   apr_req_if.sink   req_bus,
   apr_rsp_if.source rsp_bus,
   apr_csr_if.sink   csr_bus,
   output logic [$clog2(MAX_FRAMES+1)-1:0] n_frames,
   output logic clear,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)*2+PAGE_BITS+11:0] tok_launch,
   input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)*2+PAGE_BITS+11:0] tok_last,
   output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)+PAGE_BITS+1:0]   upd_out
);
   import apr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES+1);

   typedef struct packed {
      logic                 valid;
      logic [PAGE_BITS-1:0] page;
      logic                 found;
      logic [IDX_W-1:0]     hit_idx;
      logic [AGE_W:0]       best_age;
      logic [IDX_W-1:0]     best_idx;
      logic                 spare;
   } token_type;

   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [IDX_W-1:0]     idx;
      logic [PAGE_BITS-1:0] page;
   } update_type;

   token_type              tok_ff;
   token_type              last;
   update_type             upd;
   logic [CFG_W-1:0]       csr_ff;
   logic                   busy_ff,  busy_in;
   logic [FAULT_W-1:0]     fault_ff, fault_in;
   result_type             rsp_ff, pend_ff, result;
   logic                   rsp_valid_ff, pend_valid_ff;
   logic                   accept, done, rsp_take;
   logic [IDX_W-1:0]       sel_idx;
   logic [IDX_W+3:0]       idx_wide;
   logic [PAGE_BITS+15:0]  page_wide;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      if (csr_ff == '0) begin
         n_frames = CNT_W'(1);
      end else if (32'(csr_ff) > MAX_FRAMES) begin
         n_frames = CNT_W'(MAX_FRAMES);
      end else begin
         n_frames = CNT_W'(csr_ff);
      end
   end

   assign req_bus.ready = !busy_ff && !pend_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign clear         = accept && req_bus.start_run;
   assign page_wide     = {PAGE_BITS'(0), req_bus.page};

   assign last     = token_type'(tok_last);
   assign done     = last.valid;
   assign sel_idx  = last.found ? last.hit_idx : last.best_idx;
   assign idx_wide = {4'b0, sel_idx};

   assign upd.valid = done;
   assign upd.hit   = last.found;
   assign upd.idx   = sel_idx;
   assign upd.page  = last.page;
   assign upd_out   = upd;
   assign tok_launch = tok_ff;

   always_comb begin
      busy_in  = busy_ff;
      fault_in = fault_ff;
      if (accept) begin
         busy_in = 1'b1;
         if (req_bus.start_run) begin
            fault_in = '0;
         end
      end else if (done) begin
         busy_in = 1'b0;
         if (!last.found && fault_ff != FAULT_MAX) begin
            fault_in = fault_ff + 1'b1;
         end
      end
   end

   assign result.hit         = last.found;
   assign result.frame_index = idx_wide[3:0];
   assign result.fault_count = fault_in;

   assign rsp_take = rsp_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= FRAMES_RESET;
         busy_ff       <= 1'b0;
         fault_ff      <= '0;
         tok_ff.valid  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            csr_ff <= csr_bus.data;
         end
         busy_ff      <= busy_in;
         fault_ff     <= fault_in;
         tok_ff.valid <= accept;
         // completed result goes to the output, or parks while the output is stalled
         if (done) begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               pend_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            if (pend_valid_ff) begin
               pend_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
      if (accept) begin
         tok_ff.page     <= page_wide[PAGE_BITS-1:0];
         tok_ff.found    <= 1'b0;
         tok_ff.hit_idx  <= '0;
         tok_ff.best_age <= {1'b1, {AGE_W{1'b0}}};
         tok_ff.best_idx <= '0;
         tok_ff.spare    <= 1'b0;
      end
      if (done) begin
         if (!rsp_valid_ff || rsp_bus.ready) begin
            rsp_ff <= result;
         end else begin
            pend_ff <= result;
         end
      end else if (rsp_take && pend_valid_ff) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hit         = rsp_ff.hit;
   assign rsp_bus.frame_index = rsp_ff.frame_index;
   assign rsp_bus.fault_count = rsp_ff.fault_count;

endmodule

// File: hdl/aging_page_replacement_core.sv
// Top level of the aging page replacement core: sequencer and chain of frame cells.
//
// Each page reference walks a chain of MAX_FRAMES frame cells, one cell per cycle,
// which finds the first resident match and the lowest-index frame of least age. The
// result is registered as the probe leaves the last cell, and in the same edge the
// chosen frame is updated and all active frames are aged. A new reference is taken
// only once the busy flag clears and no result is parked, so a reference's stay
// is set by the probe's trip through the cell chain. A finished result waits in the
// output register (with one more holding slot) while the next reference is already
// in the chain. The frame count register is written through the always-ready csr
// channel; the user must write it only while the core is idle (the core itself does
// not enforce this). Values of zero act as one and above MAX_FRAMES as MAX_FRAMES.
module aging_page_replacement_core #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 16
) (
   input logic clock,
   input logic reset,
   apr_req_if.sink   req_bus,
   apr_rsp_if.source rsp_bus,
   apr_csr_if.sink   csr_bus
);
   import apr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES+1);
   localparam int TOK_W = IDX_W*2 + PAGE_BITS + 12;
   localparam int UPD_W = IDX_W + PAGE_BITS + 2;

   logic [CNT_W-1:0] n_frames;
   logic             clear;
   logic [TOK_W-1:0] tok_chain [MAX_FRAMES+1];
   logic [UPD_W-1:0] upd;

   apr_ctrl #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .n_frames   (n_frames),
      .clear      (clear),
      .tok_launch (tok_chain[0]),
      .tok_last   (tok_chain[MAX_FRAMES]),
      .upd_out    (upd)
   );

   for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
      apr_cell #(
         .MAX_FRAMES (MAX_FRAMES),
         .PAGE_BITS  (PAGE_BITS),
         .K          (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .n_frames (n_frames),
         .clear    (clear),
         .tok_in   (tok_chain[k]),
         .tok_out  (tok_chain[k+1]),
         .upd_in   (upd)
      );
   end

endmodule
